### rtl/core/mtes_pkg.sv
// Package: item types and event action codes for the MIDI track event serializer.
package mtes_pkg;

  localparam logic [2:0] ACT_NOTE_ON   = 3'd0;
  localparam logic [2:0] ACT_NOTE_OFF  = 3'd1;
  localparam logic [2:0] ACT_PROGRAM   = 3'd2;
  localparam logic [2:0] ACT_TEMPO     = 3'd3;
  localparam logic [2:0] ACT_END_TRACK = 3'd4;

  localparam int unsigned MAX_BYTES = 7;

  typedef struct packed {
    logic [2:0]  action;
    logic [27:0] delta_time;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [6:0]  program_req;
    logic [23:0] quarter_us;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

### rtl/core/midi_track_event_serializer.sv
// Top level: serializes one MIDI track event into its Standard MIDI File bytes.
//
//  channel | ports                         | moves
//  --------+-------------------------------+------------------------------------------
//  input   | in_valid, in_ready, in_data   | one track event per item
//  result  | out_valid, out_ready, out_data| one file byte per item, last flags the end
//
// An event is expanded into a byte buffer in the cycle it is accepted; the
// buffer then feeds the output register at one byte per cycle unless the
// output stalls. An event has 3 to 7 bytes (4 to 7 for notes, 7 for tempo).
// The next event is taken in the cycle its predecessor's last byte moves to the
// output register, so events run back to back. Unknown action codes are
// accepted and dropped. Reset (rst_n, synchronous, active low) empties the
// buffer and output register. A stalled output holds its byte and backs up
// through the buffer to in_ready.
module midi_track_event_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtes_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtes_pkg::out_item_t out_data
);
  import mtes_pkg::*;

  // byte buffer holding the expanded event
  logic [7:0] buf_r [MAX_BYTES];
  logic [7:0] buf_nxt [MAX_BYTES];
  logic [2:0] idx_r;        // next byte to hand over
  logic [2:0] last_idx_r;   // index of the event's final byte
  logic [2:0] last_idx_nxt;
  logic       buf_valid_r;
  logic       evt_ok;       // action code is a known one

  // output register
  logic       out_valid_r;
  out_item_t  out_r;

  logic       out_load;     // output register may take a new byte
  logic       buf_pop;      // a buffered byte moves to the output register
  logic       buf_done;     // that byte is the event's last one
  logic       in_acc;

  // delta-time groups, most significant first
  logic [6:0] g3, g2, g1, g0;
  logic [7:0] status;

  assign out_load = !out_valid_r || out_ready;
  assign buf_pop  = buf_valid_r && out_load;
  assign buf_done = buf_pop && (idx_r == last_idx_r);
  assign in_ready = !buf_valid_r || buf_done;
  assign in_acc   = in_valid && in_ready;

  assign g3 = in_data.delta_time[27:21];
  assign g2 = in_data.delta_time[20:14];
  assign g1 = in_data.delta_time[13:7];
  assign g0 = in_data.delta_time[6:0];

  assign status = {(in_data.action == ACT_NOTE_ON) ? 4'h9 : 4'h8, in_data.channel};

  // Expand the incoming event into bytes; unused slots are left as zero.
  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      buf_nxt[k] = 8'h00;
    end
    last_idx_nxt = 3'd0;
    evt_ok       = 1'b1;
    case (in_data.action)
      ACT_NOTE_ON, ACT_NOTE_OFF: begin
        if (g3 != 7'd0) begin
          // four-byte delta
          buf_nxt[0] = {1'b1, g3};
          buf_nxt[1] = {1'b1, g2};
          buf_nxt[2] = {1'b1, g1};
          buf_nxt[3] = {1'b0, g0};
          buf_nxt[4] = status;
          buf_nxt[5] = {1'b0, in_data.key};
          buf_nxt[6] = {1'b0, in_data.velocity};
          last_idx_nxt = 3'd6;
        end else if (g2 != 7'd0) begin
          buf_nxt[0] = {1'b1, g2};
          buf_nxt[1] = {1'b1, g1};
          buf_nxt[2] = {1'b0, g0};
          buf_nxt[3] = status;
          buf_nxt[4] = {1'b0, in_data.key};
          buf_nxt[5] = {1'b0, in_data.velocity};
          last_idx_nxt = 3'd5;
        end else if (g1 != 7'd0) begin
          buf_nxt[0] = {1'b1, g1};
          buf_nxt[1] = {1'b0, g0};
          buf_nxt[2] = status;
          buf_nxt[3] = {1'b0, in_data.key};
          buf_nxt[4] = {1'b0, in_data.velocity};
          last_idx_nxt = 3'd4;
        end else begin
          buf_nxt[0] = {1'b0, g0};
          buf_nxt[1] = status;
          buf_nxt[2] = {1'b0, in_data.key};
          buf_nxt[3] = {1'b0, in_data.velocity};
          last_idx_nxt = 3'd3;
        end
      end
      ACT_PROGRAM: begin
        buf_nxt[1] = {4'hC, in_data.channel};
        buf_nxt[2] = {1'b0, in_data.program_req};
        last_idx_nxt = 3'd2;
      end
      ACT_TEMPO: begin
        // meta event FF 51 03 then 24-bit tempo, big-endian
        buf_nxt[1] = 8'hFF;
        buf_nxt[2] = 8'h51;
        buf_nxt[3] = 8'h03;
        buf_nxt[4] = in_data.quarter_us[23:16];
        buf_nxt[5] = in_data.quarter_us[15:8];
        buf_nxt[6] = in_data.quarter_us[7:0];
        last_idx_nxt = 3'd6;
      end
      ACT_END_TRACK: begin
        // meta event FF 2F 00
        buf_nxt[1] = 8'hFF;
        buf_nxt[2] = 8'h2F;
        last_idx_nxt = 3'd3;
      end
      default: begin
        evt_ok = 1'b0;   // unknown action: item dropped
      end
    endcase
  end

  // buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (in_acc) begin
      buf_valid_r <= evt_ok;
      idx_r       <= 3'd0;
    end else if (buf_done) begin
      buf_valid_r <= 1'b0;
    end else if (buf_pop) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
        buf_r[k] <= buf_nxt[k];
      end
      last_idx_r <= last_idx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= buf_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_pop) begin
      out_r.out_byte <= buf_r[idx_r];
      out_r.last     <= (idx_r == last_idx_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a non-final byte leaving means the rest of its event is still buffered
  a_rest_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |-> buf_valid_r)
    else $error("event bytes lost after non-final byte");

  // the buffer index never runs past the event's final byte
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r |-> (idx_r <= last_idx_r))
    else $error("buffer index beyond last byte");

  // a known event fills the buffer at its first byte
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && evt_ok) |=> (buf_valid_r && idx_r == 3'd0))
    else $error("accepted event not buffered");

  // a new item is only taken while the buffer is empty or draining its last byte
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && buf_valid_r) |-> buf_done)
    else $error("event accepted over a pending one");

endmodule
